@@ rtl/core/sid_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed integer divider package
// Shared constants and the control word that travels along the cell chain.
// ----------------------------------------------------------------------------
package sid_pkg;

  // default operand width
  localparam int unsigned DataWidthDef = 32;

  // control that rides alongside each request through the chain
  typedef struct packed {
    logic vld;   // stage holds a live request
    logic neg;   // operand signs differ, negate the magnitude at the end
    logic ovf;   // most negative by minus one, saturate
    logic zdiv;  // divisor was zero
  } sid_ctl_t;

endpackage

@@ rtl/core/sid_if.sv @@
// ----------------------------------------------------------------------------
// Signed integer divider channels
// Operand request channel and quotient result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sid_req_if #(
  parameter int unsigned DATA_WIDTH = sid_pkg::DataWidthDef
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] dividend;
  logic signed [DATA_WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface sid_res_if #(
  parameter int unsigned DATA_WIDTH = sid_pkg::DataWidthDef
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quotient;
  logic                         overflowed;
  logic                         zero_divisor;

  modport source (output valid, output quotient, output overflowed,
                  output zero_divisor, input ready);
  modport sink   (input valid, input quotient, input overflowed,
                  input zero_divisor, output ready);
endinterface

@@ rtl/core/sid_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step: settles one quotient bit and registers the partial state.
// ----------------------------------------------------------------------------
module sid_cell
  import sid_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  sid_ctl_t              ctl_i,
  input  logic [DATA_WIDTH-1:0] rem_i,
  input  logic [DATA_WIDTH-1:0] acc_i,
  input  logic [DATA_WIDTH-1:0] dvs_i,
  output sid_ctl_t              ctl_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] acc_o,
  output logic [DATA_WIDTH-1:0] dvs_o
);

  logic [DATA_WIDTH-1:0] trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;
  logic [DATA_WIDTH-1:0] rem_d, rem_q;
  logic [DATA_WIDTH-1:0] acc_d, acc_q;
  logic [DATA_WIDTH-1:0] dvs_q;
  sid_ctl_t              ctl_q;

  // remainder stays below the divisor, so the shifted trial fits the word
  assign trial = {rem_i[DATA_WIDTH-2:0], acc_i[DATA_WIDTH-1]};
  assign diff  = {1'b0, trial} - {1'b0, dvs_i};
  assign fits  = ~diff[DATA_WIDTH];
  assign rem_d = fits ? diff[DATA_WIDTH-1:0] : trial;
  // dividend bits leave at the top, quotient bits enter at the bottom
  assign acc_d = {acc_i[DATA_WIDTH-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q <= rem_d;
      acc_q <= acc_d;
      dvs_q <= dvs_i;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign acc_o = acc_q;
  assign dvs_o = dvs_q;

endmodule

@@ rtl/core/signed_integer_divider.sv @@
// ----------------------------------------------------------------------------
// Signed integer divider
// Quotient truncated toward zero, computed by a chain of restoring cells.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                  | accepted when
//  --------+-----+------------------------------------------+----------------------
//  req_i   | in  | dividend, divisor                        | valid & ready
//  res_o   | out | quotient, overflowed, zero_divisor       | valid & ready
//
//  The chain is one setup stage forming the operand magnitudes, one cell per
//  quotient bit, and one sign fix-up stage that is also the output register.
//  A new request may enter every cycle while the chain is not held.
//  Reset clears the valid bits of every stage; payload is not reset.
//  While a result waits unread in the output register the whole chain holds
//  and req_i.ready drops; a bubble in the output register lets it move again.
//
module signed_integer_divider
  import sid_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sid_req_if.sink   req_i,
  sid_res_if.source res_o
);

  localparam int unsigned W = DATA_WIDTH;

  // ---------------------------------------------------------------------------
  // global advance: everything moves unless the output holds an unread result
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_vld_q;

  assign adv         = ~out_vld_q | res_o.ready;
  assign req_i.ready = adv;

  // ---------------------------------------------------------------------------
  // setup stage: magnitudes, sign and special cases
  // ---------------------------------------------------------------------------
  logic [W-1:0] a_raw, b_raw;
  logic         neg_a, neg_b;
  sid_ctl_t     ctl_d, ctl0_q;
  logic [W-1:0] acc0_q, dvs0_q;

  assign a_raw = req_i.dividend;
  assign b_raw = req_i.divisor;
  assign neg_a = a_raw[W-1];
  assign neg_b = b_raw[W-1];

  always_comb begin
    ctl_d.vld  = req_i.valid;
    ctl_d.neg  = neg_a ^ neg_b;
    ctl_d.zdiv = (b_raw == '0);
    // most negative value by minus one does not fit, flag it for saturation
    ctl_d.ovf  = (a_raw == {1'b1, {(W-1){1'b0}}}) && (b_raw == {W{1'b1}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else if (adv) begin
      ctl0_q <= ctl_d;
    end
  end

  // the most negative value negates to itself, which reads right as unsigned
  always_ff @(posedge clk_i) begin
    if (adv) begin
      acc0_q <= neg_a ? (~a_raw + {{(W-1){1'b0}}, 1'b1}) : a_raw;
      dvs0_q <= neg_b ? (~b_raw + {{(W-1){1'b0}}, 1'b1}) : b_raw;
    end
  end

  // ---------------------------------------------------------------------------
  // chain of cells, one quotient bit each
  // ---------------------------------------------------------------------------
  sid_ctl_t     ctl_c [W+1];
  logic [W-1:0] rem_c [W+1];
  logic [W-1:0] acc_c [W+1];
  logic [W-1:0] dvs_c [W+1];

  assign ctl_c[0] = ctl0_q;
  assign rem_c[0] = '0;
  assign acc_c[0] = acc0_q;
  assign dvs_c[0] = dvs0_q;

  for (genvar i = 0; i < W; i++) begin : g_cell
    sid_cell #(
      .DATA_WIDTH(W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .ctl_i (ctl_c[i]),
      .rem_i (rem_c[i]),
      .acc_i (acc_c[i]),
      .dvs_i (dvs_c[i]),
      .ctl_o (ctl_c[i+1]),
      .rem_o (rem_c[i+1]),
      .acc_o (acc_c[i+1]),
      .dvs_o (dvs_c[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // sign fix-up and output register
  // ---------------------------------------------------------------------------
  sid_ctl_t     ctl_n;
  logic [W-1:0] mq;
  logic [W-1:0] quo_d, quo_q;
  logic         ovf_q, zdiv_q;

  assign ctl_n = ctl_c[W];
  assign mq    = acc_c[W];

  always_comb begin
    priority if (ctl_n.zdiv) begin
      quo_d = '0;
    end else if (ctl_n.ovf) begin
      quo_d = {1'b0, {(W-1){1'b1}}};
    end else if (ctl_n.neg) begin
      quo_d = ~mq + {{(W-1){1'b0}}, 1'b1};
    end else begin
      quo_d = mq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= ctl_n.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quo_q  <= quo_d;
      ovf_q  <= ctl_n.ovf;
      zdiv_q <= ctl_n.zdiv;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.quotient     = quo_q;
  assign res_o.overflowed   = ovf_q;
  assign res_o.zero_divisor = zdiv_q;

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Signed integer divider testbench
// Drives operand requests through the divider with random gaps and stalls.
// Every quotient is checked against a behavioural divide and its flags.
// ----------------------------------------------------------------------------
module testbench;
  import sid_pkg::*;

  localparam int unsigned W = DataWidthDef;

  // corner operand values
  localparam logic [W-1:0] MOST_NEG  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS  = ~MOST_NEG;
  localparam logic [W-1:0] MINUS_ONE = '1;
  localparam logic [W-1:0] PLUS_ONE  = 1;

  localparam int RAND_ITEMS  = 1150;
  localparam int STALL_LIMIT = 2000;  // cycles with no handshake on either side
  localparam int HOLD_CYCLES = 150;   // receiver hold-off, well past chain depth
  localparam int DRAIN_WAIT  = 2 * (W + 2);
  localparam int PRINT_CAP   = 200;

  typedef struct packed {
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
  } operands_t;

  typedef struct packed {
    logic [W-1:0] quotient;
    logic         overflowed;
    logic         zero_divisor;
  } quot_t;

  logic clk_i;
  logic rst_ni;

  sid_req_if #(.DATA_WIDTH(W)) req_if ();
  sid_res_if #(.DATA_WIDTH(W)) res_if ();

  signed_integer_divider #(
    .DATA_WIDTH(W)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  operands_t operands_q[$];   // requests not yet offered
  quot_t     quotients_q[$];  // quotients owed by the divider, oldest first

  int  errors       = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  stall_cycles = 0;
  int  hold_left    = 0;
  bit  hold_done    = 0;
  bit  req_took     = 0;      // request accepted at the last rising edge

  // --------------------------------------------------------------------------
  // Behavioural divide: magnitudes one bit wider than the operands so the
  // most negative value has a positive magnitude; truncation toward zero falls
  // out of dividing magnitudes and fixing the sign afterwards.
  // --------------------------------------------------------------------------
  function automatic quot_t predict_quotient(logic [W-1:0] dvd, logic [W-1:0] dvs);
    logic [W:0] mag_a;
    logic [W:0] mag_b;
    logic [W:0] mag_q;
    quot_t      r;
    r = '0;
    if (dvs == '0) begin
      r.zero_divisor = 1'b1;
    end else if (dvd == MOST_NEG && dvs == MINUS_ONE) begin
      // the one quotient that does not fit: saturate
      r.quotient   = MOST_POS;
      r.overflowed = 1'b1;
    end else begin
      mag_a = dvd[W-1] ? -{1'b1, dvd} : {1'b0, dvd};
      mag_b = dvs[W-1] ? -{1'b1, dvs} : {1'b0, dvs};
      mag_q = mag_a / mag_b;
      r.quotient = (dvd[W-1] != dvs[W-1]) ? -mag_q[W-1:0] : mag_q[W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    if (errors < PRINT_CAP)
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what,
               $signed(got), $signed(want));
    errors++;
  endtask

  // random word of random magnitude, sign kept by the arithmetic shift
  function automatic logic [W-1:0] rand_word();
    logic signed [W-1:0] w;
    w = $urandom;
    return w >>> $urandom_range(W-1, 0);
  endfunction

  function automatic logic [W-1:0] corner_word();
    case ($urandom_range(5, 0))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return MINUS_ONE;
      3:       return '0;
      4:       return PLUS_ONE;
      default: return rand_word();
    endcase
  endfunction

  task automatic push_operands(logic [W-1:0] dvd, logic [W-1:0] dvs);
    operands_q.push_back('{dividend: dvd, divisor: dvs});
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Request driver: changes on the falling edge. A request stays up until the
  // rising edge has taken it; ~20% idle gaps, none while the receiver is
  // holding off (so the chain backs up) and none in a quiet window.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_requests
    operands_t op;
    bit        quiet;
    if (rst_ni) begin
      quiet = (items_sent >= 300 && items_sent < 500) || hold_left != 0;
      if (!req_if.valid || req_took) begin
        if (operands_q.size() != 0 && (quiet || $urandom_range(99, 0) >= 20)) begin
          op = operands_q.pop_front();
          req_if.valid    <= 1'b1;
          req_if.dividend <= op.dividend;
          req_if.divisor  <= op.divisor;
          items_sent++;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: ready also changes on the falling edge. One long
  // hold-off once the run is well under way, a quiet window, ~20% stalls else.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_seen >= 800) begin
        res_if.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (results_seen >= 300 && results_seen < 500) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99, 0) >= 20);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both handshakes on the rising edge. Results are checked
  // before the new request is predicted; with the chain this deep the two
  // can never refer to the same request anyway.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_channels
    quot_t want;
    bit    req_fire;
    bit    res_fire;
    if (rst_ni) begin
      req_fire = req_if.valid && req_if.ready;
      res_fire = res_if.valid && res_if.ready;
      req_took <= req_fire;

      if (res_fire) begin
        results_seen++;
        if (quotients_q.size() == 0) begin
          if (errors < PRINT_CAP)
            $display("%0t result with no request outstanding: %0d", $time,
                     $signed(res_if.quotient));
          errors++;
        end else begin
          want = quotients_q.pop_front();
          if (res_if.quotient !== want.quotient)
            report_mismatch("quotient", res_if.quotient, want.quotient);
          if (res_if.overflowed !== want.overflowed)
            report_mismatch("overflowed", W'(res_if.overflowed), W'(want.overflowed));
          if (res_if.zero_divisor !== want.zero_divisor)
            report_mismatch("zero_divisor", W'(res_if.zero_divisor),
                            W'(want.zero_divisor));
        end
      end

      if (req_fire)
        quotients_q.push_back(predict_quotient(req_if.dividend, req_if.divisor));

      // watchdog on lack of progress
      if (req_fire || res_fire) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("[signed_integer_divider] ERROR");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : run
    int                  pick;
    logic signed [W-1:0] dvs;
    logic signed [W-1:0] dvd;

    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.dividend = '0;
    req_if.divisor  = '0;
    res_if.ready    = 1'b0;

    // directed: saturation, zero divisor, most negative by one, zero
    // dividend of either divisor sign, truncation in all four sign quadrants
    push_operands(MOST_NEG, MINUS_ONE);
    push_operands(MOST_NEG, '0);
    push_operands(MOST_POS, '0);
    push_operands('0, '0);
    push_operands(MINUS_ONE, '0);
    push_operands(MOST_NEG, PLUS_ONE);
    push_operands('0, W'(-5));
    push_operands('0, W'(5));
    push_operands('0, MOST_NEG);
    push_operands(MOST_POS, MOST_POS);
    push_operands(MOST_NEG, MOST_NEG);
    push_operands(MOST_NEG, MOST_POS);
    push_operands(MOST_POS, MOST_NEG);
    push_operands(MOST_POS, MINUS_ONE);
    push_operands(W'(7), W'(2));
    push_operands(W'(-7), W'(2));
    push_operands(W'(7), W'(-2));
    push_operands(W'(-7), W'(-2));
    push_operands(PLUS_ONE, MOST_NEG);
    push_operands(MINUS_ONE, MOST_NEG);
    push_operands(MOST_NEG, W'(2));
    push_operands(MOST_NEG, W'(-2));
    push_operands(W'(5), W'(7));

    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 45) begin
        push_operands(rand_word(), rand_word());
      end else if (pick < 65) begin
        // tiny divisors give long quotients
        dvs = $urandom_range(16, 0);
        if ($urandom_range(1, 0)) dvs = -dvs;
        push_operands($urandom, dvs);
      end else if (pick < 85) begin
        // near-exact multiples exercise the rounding boundary
        dvs = rand_word() >>> $urandom_range(W/2, 0);
        dvd = dvs * $signed($urandom_range(9, 0)) + $signed($urandom_range(4, 0)) - 2;
        if ($urandom_range(1, 0)) dvd = -dvd;
        push_operands(dvd, dvs);
      end else begin
        push_operands(corner_word(), corner_word());
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every request taken, then every quotient back, then a quiet spell
    while (operands_q.size() != 0 || req_if.valid) @(negedge clk_i);
    while (quotients_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (errors == 0) begin
      $display("[signed_integer_divider] OK");
    end else begin
      $display("[signed_integer_divider] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sid_pkg.sv
rtl/core/sid_if.sv
rtl/core/sid_cell.sv
rtl/core/signed_integer_divider.sv
dv/testbench.sv
